// ===== sv/rsape_pkg.sv =====
// ============================================================================
// rsape_pkg: shared types, constants and microcode for the RSA key core
// Control word layout, datapath actions, jump conditions and program ROM.
// ============================================================================
package rsape_pkg;

  // Field widths fixed by the channel format
  localparam int unsigned PRIME_W     = 31;
  localparam int unsigned OPER_W      = 62;
  localparam int unsigned SIGNED_W    = 64;
  localparam int unsigned PRIME_BITS  = 31;

  // Euclid iteration cap
  localparam int unsigned EUCLID_MAX_STEPS = 128;
  localparam int unsigned STEP_CNT_W       = $clog2(EUCLID_MAX_STEPS + 1);

  // Program counter
  localparam int unsigned PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // Program step addresses
  localparam pc_t PC_IDLE   = 4'd0;
  localparam pc_t PC_MUL_N  = 4'd1;
  localparam pc_t PC_MUL_T  = 4'd2;
  localparam pc_t PC_INIT   = 4'd3;
  localparam pc_t PC_DIV_S  = 4'd4;
  localparam pc_t PC_WAIT_S = 4'd5;
  localparam pc_t PC_SET_R1 = 4'd6;
  localparam pc_t PC_TEST   = 4'd7;
  localparam pc_t PC_DIV_R  = 4'd8;
  localparam pc_t PC_WAIT_R = 4'd9;
  localparam pc_t PC_UPDATE = 4'd10;
  localparam pc_t PC_FINISH = 4'd11;
  localparam pc_t PC_PUSH   = 4'd12;
  localparam pc_t PC_WRAP   = 4'd13;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,     // take a request from the input channel
    ACT_MUL_N,    // n = p * q
    ACT_MUL_T,    // t = (p-1)(q-1), or 0 for a factor below two
    ACT_INIT,     // r0 = t, x0 = 0, x1 = 1, clear result
    ACT_DIV_S,    // start s / t
    ACT_SET_R1,   // r1 = s mod t
    ACT_DIV_R,    // start r0 / r1, accumulating q * x1
    ACT_UPDATE,   // shift the Euclid pair
    ACT_FINISH,   // form flag and inverse
    ACT_PUSH      // load the output register
  } act_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_DIV_BUSY,
    COND_T_ZERO,
    COND_LOOP_DONE,
    COND_OUT_BUSY,
    COND_ALWAYS
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    pc_t   target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic div_busy;
    logic t_zero;
    logic loop_done;
    logic out_busy;
  } flags_t;

  // Microcode ROM: jump to target when cond holds, else fall through
  function automatic ctrl_t ucode_rom(pc_t pc);
    ctrl_t cw;
    cw = '{act: ACT_NONE, cond: COND_ALWAYS, target: PC_IDLE};
    case (pc)
      PC_IDLE:   cw = '{act: ACT_LOAD,   cond: COND_NO_INPUT,  target: PC_IDLE};
      PC_MUL_N:  cw = '{act: ACT_MUL_N,  cond: COND_NEVER,     target: PC_IDLE};
      PC_MUL_T:  cw = '{act: ACT_MUL_T,  cond: COND_NEVER,     target: PC_IDLE};
      PC_INIT:   cw = '{act: ACT_INIT,   cond: COND_T_ZERO,    target: PC_PUSH};
      PC_DIV_S:  cw = '{act: ACT_DIV_S,  cond: COND_NEVER,     target: PC_IDLE};
      PC_WAIT_S: cw = '{act: ACT_NONE,   cond: COND_DIV_BUSY,  target: PC_WAIT_S};
      PC_SET_R1: cw = '{act: ACT_SET_R1, cond: COND_NEVER,     target: PC_IDLE};
      PC_TEST:   cw = '{act: ACT_NONE,   cond: COND_LOOP_DONE, target: PC_FINISH};
      PC_DIV_R:  cw = '{act: ACT_DIV_R,  cond: COND_NEVER,     target: PC_IDLE};
      PC_WAIT_R: cw = '{act: ACT_NONE,   cond: COND_DIV_BUSY,  target: PC_WAIT_R};
      PC_UPDATE: cw = '{act: ACT_UPDATE, cond: COND_ALWAYS,    target: PC_TEST};
      PC_FINISH: cw = '{act: ACT_FINISH, cond: COND_NEVER,     target: PC_IDLE};
      PC_PUSH:   cw = '{act: ACT_PUSH,   cond: COND_OUT_BUSY,  target: PC_PUSH};
      PC_WRAP:   cw = '{act: ACT_NONE,   cond: COND_ALWAYS,    target: PC_IDLE};
      default:   cw = '{act: ACT_NONE,   cond: COND_ALWAYS,    target: PC_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// ===== sv/rsape_if.sv =====
// ============================================================================
// rsape channel interfaces
// Valid/ready channels for key requests and key results.
// ============================================================================
interface rsape_in_if;
  logic                               valid;
  logic                               ready;
  logic [rsape_pkg::PRIME_W-1:0]      prime_a;
  logic [rsape_pkg::PRIME_W-1:0]      prime_b;
  logic [rsape_pkg::OPER_W-1:0]       candidate_exponent;

  modport source (output valid, prime_a, prime_b, candidate_exponent, input ready);
  modport sink   (input valid, prime_a, prime_b, candidate_exponent, output ready);
endinterface

interface rsape_out_if;
  logic                               valid;
  logic                               ready;
  logic [rsape_pkg::OPER_W-1:0]       modulus;
  logic                               coprime_ok;
  logic [rsape_pkg::OPER_W-1:0]       private_exponent;

  modport source (output valid, modulus, coprime_ok, private_exponent, input ready);
  modport sink   (input valid, modulus, coprime_ok, private_exponent, output ready);
endinterface

// ===== sv/rsape_divider.sv =====
// ============================================================================
// rsape_divider: bit-serial restoring divider
// One quotient bit per cycle; also accumulates quotient * mult (Horner).
// ============================================================================
module rsape_divider #(
  parameter int unsigned DataW = rsape_pkg::OPER_W,
  parameter int unsigned AccW  = rsape_pkg::SIGNED_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [DataW-1:0]       dividend_i,
  input  logic [DataW-1:0]       divisor_i,
  input  logic signed [AccW-1:0] mult_i,
  output logic                   busy_o,
  output logic [DataW-1:0]       rem_o,
  output logic signed [AccW-1:0] prod_o
);

  localparam int unsigned CntW = $clog2(DataW + 1);

  logic                   busy_q, busy_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [DataW-1:0]       rem_q, rem_d;
  logic [DataW-1:0]       dvd_q, dvd_d;
  logic [DataW-1:0]       dsr_q, dsr_d;
  logic signed [AccW-1:0] mlt_q, mlt_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic [DataW:0]         shifted;
  logic [DataW:0]         diff;
  logic                   qbit;

  assign shifted = {rem_q, dvd_q[DataW-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign qbit    = (shifted >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    mlt_d  = mlt_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DataW);
      rem_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      mlt_d  = mult_i;
      acc_d  = '0;
    end else if (busy_q) begin
      rem_d  = qbit ? diff[DataW-1:0] : shifted[DataW-1:0];
      dvd_d  = {dvd_q[DataW-2:0], 1'b0};
      acc_d  = (acc_q <<< 1) + (qbit ? mlt_q : AccW'(0));
      cnt_d  = cnt_q - CntW'(1);
      busy_d = (cnt_q != CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    mlt_q <= mlt_d;
    acc_q <= acc_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;
  assign prod_o = acc_q;

endmodule

// ===== sv/rsape_seq.sv =====
// ============================================================================
// rsape_seq: microcode sequencer
// Step counter over the program ROM with conditional jumps.
// ============================================================================
module rsape_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsape_pkg::flags_t flags_i,
  output rsape_pkg::ctrl_t  ctrl_o
);

  rsape_pkg::pc_t   pc_q, pc_d;
  rsape_pkg::ctrl_t cw;
  logic             take;

  assign cw = rsape_pkg::ucode_rom(pc_q);

  always_comb begin
    case (cw.cond)
      rsape_pkg::COND_NEVER:     take = 1'b0;
      rsape_pkg::COND_NO_INPUT:  take = !flags_i.in_valid;
      rsape_pkg::COND_DIV_BUSY:  take = flags_i.div_busy;
      rsape_pkg::COND_T_ZERO:    take = flags_i.t_zero;
      rsape_pkg::COND_LOOP_DONE: take = flags_i.loop_done;
      rsape_pkg::COND_OUT_BUSY:  take = flags_i.out_busy;
      rsape_pkg::COND_ALWAYS:    take = 1'b1;
      default:                   take = 1'b1;
    endcase
    pc_d = take ? cw.target : pc_q + rsape_pkg::pc_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= rsape_pkg::PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = cw;

endmodule

// ===== sv/rsa_private_exponent_from_primes_core.sv =====
// ============================================================================
// rsa_private_exponent_from_primes_core: RSA modulus and private exponent
// Gives n = p*q and the inverse of a candidate exponent modulo (p-1)(q-1).
// ============================================================================
// Usage:
//   in_i  (sink):   one request = prime_a, prime_b, candidate_exponent.
//                   Only the low PRIME_BITS bits of each prime are used.
//   out_o (source): one result per request = modulus, coprime_ok,
//                   private_exponent (0 when the candidate is not coprime).
// Sequence: after the accept, the core forms n and t, divides s by t and
//   then runs the Euclid steps (at most about 90 for 62-bit operands, capped
//   at EUCLID_MAX_STEPS) before it forms the result and pushes it to out_o;
//   with a zero totient it goes from its init step straight to the push step.
//   Each Euclid step is one pass of the bit-serial divider, at one quotient
//   bit per cycle, plus 4 microcode steps.
// Requests: one at a time; in_i.ready is high only while the sequencer sits at
//   its idle step.
// Stall: the result sits in an output register. The sequencer waits at
//   its push step only if the previous result has not been taken yet.
// Reset: rst_ni (async, active low) returns the step counter to idle and
//   empties the output register; no clearing pass is needed.
// Control: a 14-step microcode ROM drives one shared 31x31 multiplier,
//   the divider and the Euclid registers r0, r1, x0, x1.
// ============================================================================
module rsa_private_exponent_from_primes_core #(
  parameter int unsigned PrimeBits = rsape_pkg::PRIME_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rsape_in_if.sink            in_i,
  rsape_out_if.source         out_o
);

  localparam int unsigned OperW = rsape_pkg::OPER_W;
  localparam int unsigned SgnW  = rsape_pkg::SIGNED_W;
  localparam int unsigned StepW = rsape_pkg::STEP_CNT_W;
  localparam int unsigned ProdW = 2 * PrimeBits;

  rsape_pkg::ctrl_t  ctrl;
  rsape_pkg::flags_t flags;

  // Operand registers
  logic [PrimeBits-1:0] p_q, q_q;
  logic [OperW-1:0]     s_q;
  logic [OperW-1:0]     n_q;
  logic [OperW-1:0]     t_q;

  // Euclid state
  logic [OperW-1:0]      r0_q, r1_q;
  logic signed [SgnW-1:0] x0_q, x1_q;
  logic [StepW-1:0]      steps_q;

  // Result staging
  logic                  ok_q;
  logic [OperW-1:0]      inv_q;

  // Output register
  logic                  out_valid_q, out_valid_d;
  logic [OperW-1:0]      out_mod_q;
  logic                  out_ok_q;
  logic [OperW-1:0]      out_inv_q;
  logic                  out_free;

  // Shared multiplier
  logic [PrimeBits-1:0]  mul_a, mul_b;
  logic [ProdW-1:0]      mul_p;
  logic                  primes_ok;

  // Divider hookup
  logic                  div_start;
  logic [OperW-1:0]      div_dvd, div_dsr;
  logic                  div_busy;
  logic [OperW-1:0]      div_rem;
  logic signed [SgnW-1:0] div_prod;

  // Finish logic
  logic signed [SgnW-1:0] x0_fix;

  rsape_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  rsape_divider #(
    .DataW (OperW),
    .AccW  (SgnW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .mult_i     (x1_q),
    .busy_o     (div_busy),
    .rem_o      (div_rem),
    .prod_o     (div_prod)
  );

  assign in_i.ready = (ctrl.act == rsape_pkg::ACT_LOAD);
  assign out_free   = !out_valid_q || out_o.ready;

  assign flags.in_valid  = in_i.valid;
  assign flags.div_busy  = div_busy;
  assign flags.t_zero    = (t_q == '0);
  assign flags.loop_done = (r1_q == '0) ||
                           (steps_q == StepW'(rsape_pkg::EUCLID_MAX_STEPS));
  assign flags.out_busy  = !out_free;

  // A factor below two gives a totient of zero
  assign primes_ok = (p_q >= PrimeBits'(2)) && (q_q >= PrimeBits'(2));

  always_comb begin
    if (ctrl.act == rsape_pkg::ACT_MUL_T) begin
      mul_a = p_q - PrimeBits'(1);
      mul_b = q_q - PrimeBits'(1);
    end else begin
      mul_a = p_q;
      mul_b = q_q;
    end
  end
  assign mul_p = mul_a * mul_b;

  assign div_start = (ctrl.act == rsape_pkg::ACT_DIV_S) ||
                     (ctrl.act == rsape_pkg::ACT_DIV_R);
  assign div_dvd   = (ctrl.act == rsape_pkg::ACT_DIV_S) ? s_q : r0_q;
  assign div_dsr   = (ctrl.act == rsape_pkg::ACT_DIV_S) ? t_q : r1_q;

  // Negative coefficient is brought into [0, t) by one add
  assign x0_fix = x0_q[SgnW-1] ? (x0_q + SgnW'(t_q)) : x0_q;

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (ctrl.act)
      rsape_pkg::ACT_LOAD: begin
        if (in_i.valid) begin
          p_q <= in_i.prime_a[PrimeBits-1:0];
          q_q <= in_i.prime_b[PrimeBits-1:0];
          s_q <= in_i.candidate_exponent;
        end
      end
      rsape_pkg::ACT_MUL_N: begin
        n_q <= OperW'(mul_p);
      end
      rsape_pkg::ACT_MUL_T: begin
        t_q <= primes_ok ? OperW'(mul_p) : '0;
      end
      rsape_pkg::ACT_INIT: begin
        r0_q    <= t_q;
        x0_q    <= '0;
        x1_q    <= SgnW'(1);
        steps_q <= '0;
        ok_q    <= 1'b0;
        inv_q   <= '0;
      end
      rsape_pkg::ACT_SET_R1: begin
        r1_q <= div_rem;
      end
      rsape_pkg::ACT_UPDATE: begin
        r0_q    <= r1_q;
        r1_q    <= div_rem;
        x0_q    <= x1_q;
        x1_q    <= x0_q - div_prod;
        steps_q <= steps_q + StepW'(1);
      end
      rsape_pkg::ACT_FINISH: begin
        ok_q  <= (r0_q == OperW'(1));
        // gcd 1 and t == 1: inverse modulo one is zero
        if ((r0_q != OperW'(1)) || (t_q == OperW'(1))) begin
          inv_q <= '0;
        end else begin
          inv_q <= x0_fix[OperW-1:0];
        end
      end
      rsape_pkg::ACT_PUSH: begin
        if (out_free) begin
          out_mod_q <= n_q;
          out_ok_q  <= ok_q;
          out_inv_q <= inv_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Output valid: set on push, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if ((ctrl.act == rsape_pkg::ACT_PUSH) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.modulus          = out_mod_q;
  assign out_o.coprime_ok       = out_ok_q;
  assign out_o.private_exponent = out_inv_q;

endmodule
